>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Both sample on i_clk and are
// disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define HSFC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

`define HSFC_ASSERT_IMP(lbl, ante, cons) \
    `HSFC_ASSERT(lbl, (ante) |-> (cons))

`endif

>>> rtl/core/hsfc_pkg.sv
`default_nettype none

package hsfc_pkg;

    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [7:0]         CRC_INIT    = 8'hFF;
    localparam logic [14:0]        TEMP_SPAN   = 15'd31500;
    localparam logic [13:0]        HUM_SPAN    = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4900;
    localparam logic [15:0]        FULL_SCALE  = 16'hFFFF;

    // Byte position inside the six-byte frame.
    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } t_pos;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] temperature_centi_f;
        logic [13:0]        humidity_centi_pct;
        logic               temperature_crc_ok;
        logic               humidity_crc_ok;
    } t_out_beat;

    // One CRC-8 byte step, MSB first, eight unrolled shifts.
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // floor(x / 65535) for x below 2^31: x = q0 * 65536 + lo, so
    // x - q0 * 65535 = lo + q0, which stays below twice the divisor.
    function automatic logic [14:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[30:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        return (rem >= {1'b0, FULL_SCALE}) ? q0 + 15'd1 : q0;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/humidity_sensor_frame_checker_top.sv
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+-----------------------------
// in      | into      | i_in_valid / o_in_ready    | i_in_beat  (hsfc_pkg::t_in_beat)
// out     | out of    | o_out_valid / i_out_ready  | o_out_beat (hsfc_pkg::t_out_beat)
//
// One byte beat is taken per cycle while o_in_ready is high. A byte is held in
// the input register; when it moves on, the sixth byte of a frame loads its
// result beat into the output register, where it waits until it is taken.
// Reset is synchronous and active low; it clears the frame position, the CRC,
// the held readings and both valid flags.
// o_in_ready drops only when the input register holds a byte while the output
// register holds a result that is not being taken that cycle.

`default_nettype none

`include "assert_macros.svh"

module humidity_sensor_frame_checker_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire hsfc_pkg::t_in_beat   i_in_beat,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output hsfc_pkg::t_out_beat       o_out_beat
);

    // Input register
    logic               r_in_valid;
    hsfc_pkg::t_in_beat r_in;

    // Frame state
    hsfc_pkg::t_pos     r_pos,         n_pos;
    logic [7:0]         r_crc,         n_crc;
    logic [7:0]         r_hi,          n_hi;
    logic               r_temp_flag,   n_temp_flag;
    logic [30:0]        r_temp_prod,   n_temp_prod;   // 31500 * raw temperature word
    logic [29:0]        r_hum_prod,    n_hum_prod;    // 10000 * raw humidity word
    logic signed [15:0] r_held_temp,   n_held_temp;
    logic [13:0]        r_held_hum,    n_held_hum;

    // Output register
    logic                r_out_valid;
    hsfc_pkg::t_out_beat r_out, n_out;

    logic               advance;
    logic               fire;
    logic               emit;
    hsfc_pkg::t_pos     eff_pos;
    logic [15:0]        raw_word;
    logic [7:0]         crc_step;
    logic [14:0]        temp_q;
    logic [14:0]        hum_q;
    logic signed [15:0] temp_val;
    logic               hum_ok;

    // The input stage moves on whenever the output register is free or drains.
    always_comb begin
        advance    = !r_out_valid || i_out_ready;
        o_in_ready = !r_in_valid || advance;
        fire       = r_in_valid && advance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_beat;
        end
    end

    // Frame decode, CRC and scaling on the registered byte.
    always_comb begin
        eff_pos  = r_in.frame_start ? hsfc_pkg::POS_T_HI : r_pos;
        raw_word = {r_hi, r_in.data_byte};
        crc_step = hsfc_pkg::crc_byte(r_crc, r_in.data_byte);
        temp_q   = hsfc_pkg::div_full_scale(r_temp_prod);
        hum_q    = hsfc_pkg::div_full_scale({1'b0, r_hum_prod});
        temp_val = $signed({1'b0, temp_q}) + hsfc_pkg::TEMP_OFFSET;
        hum_ok   = (r_crc == r_in.data_byte);

        n_pos       = r_pos;
        n_crc       = r_crc;
        n_hi        = r_hi;
        n_temp_flag = r_temp_flag;
        n_temp_prod = r_temp_prod;
        n_hum_prod  = r_hum_prod;
        n_held_temp = r_held_temp;
        n_held_hum  = r_held_hum;
        emit        = 1'b0;

        n_out.temperature_centi_f = r_held_temp;
        n_out.humidity_centi_pct  = r_held_hum;
        n_out.temperature_crc_ok  = r_temp_flag;
        n_out.humidity_crc_ok     = hum_ok;

        if (fire) begin
            unique case (eff_pos)
                hsfc_pkg::POS_T_HI: begin
                    n_crc = hsfc_pkg::crc_byte(hsfc_pkg::CRC_INIT, r_in.data_byte);
                    n_hi  = r_in.data_byte;
                    n_pos = hsfc_pkg::POS_T_LO;
                end
                hsfc_pkg::POS_H_HI: begin
                    n_crc = hsfc_pkg::crc_byte(hsfc_pkg::CRC_INIT, r_in.data_byte);
                    n_hi  = r_in.data_byte;
                    n_pos = hsfc_pkg::POS_H_LO;
                end
                hsfc_pkg::POS_T_LO: begin
                    n_crc       = crc_step;
                    n_temp_prod = 31'(raw_word) * 31'(hsfc_pkg::TEMP_SPAN);
                    n_pos       = hsfc_pkg::POS_T_CRC;
                end
                hsfc_pkg::POS_T_CRC: begin
                    n_temp_flag = (r_crc == r_in.data_byte);
                    n_crc       = hsfc_pkg::CRC_INIT;
                    n_pos       = hsfc_pkg::POS_H_HI;
                end
                hsfc_pkg::POS_H_LO: begin
                    n_crc      = crc_step;
                    n_hum_prod = 30'(raw_word) * 30'(hsfc_pkg::HUM_SPAN);
                    n_pos      = hsfc_pkg::POS_H_CRC;
                end
                default: begin
                    // Last byte: check humidity CRC, update held readings, emit.
                    n_crc = hsfc_pkg::CRC_INIT;
                    n_pos = hsfc_pkg::POS_T_HI;
                    emit  = 1'b1;
                    if (r_temp_flag) begin
                        n_held_temp = temp_val;
                    end
                    if (hum_ok) begin
                        n_held_hum = hum_q[13:0];
                    end
                    n_out.temperature_centi_f = n_held_temp;
                    n_out.humidity_centi_pct  = n_held_hum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= hsfc_pkg::POS_T_HI;
            r_crc       <= hsfc_pkg::CRC_INIT;
            r_hi        <= '0;
            r_temp_flag <= 1'b0;
            r_held_temp <= '0;
            r_held_hum  <= '0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_hi        <= n_hi;
            r_temp_flag <= n_temp_flag;
            r_held_temp <= n_held_temp;
            r_held_hum  <= n_held_hum;
        end
    end

    // Products are written before they are read in every frame.
    always_ff @(posedge i_clk) begin
        r_temp_prod <= n_temp_prod;
        r_hum_prod  <= n_hum_prod;
    end

    // Output register: load on the last byte, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    `HSFC_ASSERT_IMP(a_result_from_last_byte, $rose(r_out_valid), $past(fire && emit))
    `HSFC_ASSERT_IMP(a_stall_only_when_full, !o_in_ready,
                     r_in_valid && r_out_valid && !i_out_ready)
    `HSFC_ASSERT_IMP(a_hum_range, r_out_valid, r_out.humidity_centi_pct <= 14'd10000)
    `HSFC_ASSERT_IMP(a_temp_range, r_out_valid,
                     (r_out.temperature_centi_f >= -16'sd4900) &&
                     (r_out.temperature_centi_f <= 16'sd26600))

endmodule

`default_nettype wire

>>> tb/sv/humidity_sensor_frame_checker_top_tb.sv
`timescale 1ns / 100ps

module humidity_sensor_frame_checker_top_tb;

    // CRC-8 generator and seed, and the conversion spans, kept local to the bench
    localparam logic [7:0]  CRC_GEN         = 8'h31;
    localparam logic [7:0]  CRC_SEED        = 8'hFF;
    localparam int unsigned TEMP_SPAN_CENTI = 31500;
    localparam int unsigned HUM_SPAN_CENTI  = 10000;
    localparam int unsigned RAW_FULL        = 65535;
    localparam int          TEMP_LOW_CENTI  = -4900;
    localparam int          RANDOM_BEATS    = 1900;

    // Readings that can be read straight off the conversion formulas
    localparam hsfc_pkg::t_out_beat READ_NONE        = '0;
    localparam hsfc_pkg::t_out_beat READ_AFTER_RESET = {16'sd0, 14'd0, 1'b0, 1'b0};
    localparam hsfc_pkg::t_out_beat READ_FULL        = {16'sd26600, 14'd10000, 1'b1, 1'b1};
    localparam hsfc_pkg::t_out_beat READ_STALE_TEMP  = {16'sd26600, 14'd0, 1'b0, 1'b1};
    localparam hsfc_pkg::t_out_beat READ_COLD        = {-16'sd4900, 14'd0, 1'b1, 1'b0};

    typedef struct packed {
        logic [7:0]          rx_byte;
        logic                start;
        logic                typed;   // use the typed-in reading instead of the tracker's
        hsfc_pkg::t_out_beat want;
    } t_frame_row;

    // Directed frames. The CRC of 0x0000 is 0x81 and of 0xFFFF is 0xAC.
    t_frame_row frame_rows [0:26] = '{
        // all-zero bytes, both CRCs wrong: held values still at their reset zero
        {8'h00, 1'b1, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b1, READ_AFTER_RESET},
        // full-scale words, good CRCs, no frame-start flag on the first byte
        {8'hFF, 1'b0, 1'b0, READ_NONE},
        {8'hFF, 1'b0, 1'b0, READ_NONE},
        {8'hAC, 1'b0, 1'b0, READ_NONE},
        {8'hFF, 1'b0, 1'b0, READ_NONE},
        {8'hFF, 1'b0, 1'b0, READ_NONE},
        {8'hAC, 1'b0, 1'b1, READ_FULL},
        // partial frame with a good zero temperature, dropped by a new start
        {8'h00, 1'b1, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h81, 1'b0, 1'b0, READ_NONE},
        // bad temperature CRC: the dropped temperature must not show up
        {8'h00, 1'b1, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h81, 1'b0, 1'b1, READ_STALE_TEMP},
        // lowest temperature, bad humidity CRC, back to back with the last frame
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b0, READ_NONE},
        {8'h81, 1'b0, 1'b0, READ_NONE},
        {8'hFF, 1'b0, 1'b0, READ_NONE},
        {8'hFF, 1'b0, 1'b0, READ_NONE},
        {8'h00, 1'b0, 1'b1, READ_COLD}
    };

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    hsfc_pkg::t_in_beat  i_in_beat   = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    hsfc_pkg::t_out_beat o_out_beat;

    // Frame tracker state, mirrors what the block holds between bytes
    hsfc_pkg::t_pos frame_pos  = hsfc_pkg::POS_T_HI;
    logic [7:0]     crc_acc    = CRC_SEED;
    logic [7:0]     hi_byte    = '0;
    logic [15:0]    temp_word  = '0;
    logic [15:0]    hum_word   = '0;
    logic           temp_good  = 1'b0;
    logic [15:0]    held_temp  = '0;
    logic [13:0]    held_hum   = '0;

    hsfc_pkg::t_out_beat pending_readings [$];
    hsfc_pkg::t_out_beat oldest_reading;
    int        n_errors    = 0;
    int        beats_sent  = 0;
    int        burst_left  = 0;
    int        ready_run   = 0;
    logic      calm        = 1'b0;   // no idling on either side while set

    humidity_sensor_frame_checker_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    // Shift the byte in one bit at a time, feedback taken from the top bit.
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_GEN : 8'h00);
        end
        return acc;
    endfunction

    // Advance the tracker by one byte; return 1 with the reading on the sixth byte.
    function automatic logic track_frame_byte(input hsfc_pkg::t_in_beat beat,
                                              output hsfc_pkg::t_out_beat reading);
        hsfc_pkg::t_pos pos;
        logic           hum_good;
        int unsigned    scaled;
        int             centi;
        reading = '0;
        pos = beat.frame_start ? hsfc_pkg::POS_T_HI : frame_pos;
        case (pos)
            hsfc_pkg::POS_T_HI, hsfc_pkg::POS_H_HI: begin
                crc_acc   = crc8_step(CRC_SEED, beat.data_byte);
                hi_byte   = beat.data_byte;
                frame_pos = (pos == hsfc_pkg::POS_T_HI) ? hsfc_pkg::POS_T_LO
                                                        : hsfc_pkg::POS_H_LO;
                return 1'b0;
            end
            hsfc_pkg::POS_T_LO: begin
                crc_acc   = crc8_step(crc_acc, beat.data_byte);
                temp_word = {hi_byte, beat.data_byte};
                frame_pos = hsfc_pkg::POS_T_CRC;
                return 1'b0;
            end
            hsfc_pkg::POS_T_CRC: begin
                temp_good = (crc_acc == beat.data_byte);
                crc_acc   = CRC_SEED;
                frame_pos = hsfc_pkg::POS_H_HI;
                return 1'b0;
            end
            hsfc_pkg::POS_H_LO: begin
                crc_acc   = crc8_step(crc_acc, beat.data_byte);
                hum_word  = {hi_byte, beat.data_byte};
                frame_pos = hsfc_pkg::POS_H_CRC;
                return 1'b0;
            end
            default: ;
        endcase
        // humidity CRC byte closes the frame
        hum_good  = (crc_acc == beat.data_byte);
        crc_acc   = CRC_SEED;
        frame_pos = hsfc_pkg::POS_T_HI;
        if (temp_good) begin
            scaled    = (TEMP_SPAN_CENTI * temp_word) / RAW_FULL;
            centi     = int'(scaled) + TEMP_LOW_CENTI;
            held_temp = centi[15:0];
        end
        if (hum_good) begin
            scaled   = (HUM_SPAN_CENTI * hum_word) / RAW_FULL;
            held_hum = scaled[13:0];
        end
        reading.temperature_centi_f = held_temp;
        reading.humidity_centi_pct  = held_hum;
        reading.temperature_crc_ok  = temp_good;
        reading.humidity_crc_ok     = hum_good;
        return 1'b1;
    endfunction

    // Favor the ends of the scale, otherwise any word.
    function automatic logic [15:0] pick_raw_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return {12'h000, r[3:0]};
            3: return {12'hFFF, r[3:0]};
            default: return r[15:0];
        endcase
    endfunction

    // Good CRC most of the time, else the good one with some bits flipped.
    function automatic logic [7:0] word_check_byte(input logic [15:0] raw);
        logic [7:0]  good;
        logic [31:0] flip;
        good = crc8_step(crc8_step(CRC_SEED, raw[15:8]), raw[7:0]);
        flip = $urandom_range(1, 255);
        return ($urandom_range(0, 3) == 0) ? good ^ flip[7:0] : good;
    endfunction

    // Offer one byte beat and hold it until taken. Called right after a rising
    // edge; gaps open only at burst boundaries so valid never drops mid-beat.
    task automatic send_byte(input logic [7:0] b, input logic start,
                             input logic typed, input hsfc_pkg::t_out_beat want);
        hsfc_pkg::t_in_beat  beat;
        hsfc_pkg::t_out_beat reading;
        beat.data_byte   = b;
        beat.frame_start = start;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!calm && $urandom_range(0, 2) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_beat  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        if (track_frame_byte(beat, reading)) begin
            pending_readings.push_back(typed ? want : reading);
        end
    endtask

    // Receiver: alternate runs of taking and stalling, always taking when calm.
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
            ready_run   <= 0;
        end else if (ready_run == 0) begin
            i_out_ready <= ~i_out_ready;
            ready_run   <= i_out_ready ? $urandom_range(1, 5) : $urandom_range(1, 12);
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // Compare every taken result beat against the oldest pending reading.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with no reading pending: %h", o_out_beat);
                n_errors++;
            end else begin
                oldest_reading = pending_readings.pop_front();
                if (o_out_beat.temperature_centi_f !== oldest_reading.temperature_centi_f) begin
                    $error("temperature_centi_f: expected %0d, got %0d",
                           oldest_reading.temperature_centi_f, o_out_beat.temperature_centi_f);
                    n_errors++;
                end
                if (o_out_beat.humidity_centi_pct !== oldest_reading.humidity_centi_pct) begin
                    $error("humidity_centi_pct: expected %0d, got %0d",
                           oldest_reading.humidity_centi_pct, o_out_beat.humidity_centi_pct);
                    n_errors++;
                end
                if (o_out_beat.temperature_crc_ok !== oldest_reading.temperature_crc_ok) begin
                    $error("temperature_crc_ok: expected %0b, got %0b",
                           oldest_reading.temperature_crc_ok, o_out_beat.temperature_crc_ok);
                    n_errors++;
                end
                if (o_out_beat.humidity_crc_ok !== oldest_reading.humidity_crc_ok) begin
                    $error("humidity_crc_ok: expected %0b, got %0b",
                           oldest_reading.humidity_crc_ok, o_out_beat.humidity_crc_ok);
                    n_errors++;
                end
            end
        end
    end

    // Stimulus: reset, the directed frames, then random traffic.
    initial begin
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        logic [7:0]  frame_bytes [0:5];
        logic [31:0] r;
        logic        need_start;
        int          kind;
        int          len;
        need_start = 1'b0;

        // hold reset, once, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (frame_rows[i]) begin
            send_byte(frame_rows[i].rx_byte, frame_rows[i].start,
                      frame_rows[i].typed, frame_rows[i].want);
        end

        while (beats_sent < RANDOM_BEATS + $size(frame_rows)) begin
            // now and then flip into or out of a stretch with no idling
            if ($urandom_range(0, 39) == 0) begin
                calm <= ~calm;
            end
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                // well-formed frame with random words and mostly good CRCs
                t_raw = pick_raw_word();
                h_raw = pick_raw_word();
                frame_bytes[0] = t_raw[15:8];
                frame_bytes[1] = t_raw[7:0];
                frame_bytes[2] = word_check_byte(t_raw);
                frame_bytes[3] = h_raw[15:8];
                frame_bytes[4] = h_raw[7:0];
                frame_bytes[5] = word_check_byte(h_raw);
                for (int k = 0; k < 6; k++) begin
                    send_byte(frame_bytes[k],
                              (k == 0) && (need_start || $urandom_range(0, 1) == 1),
                              1'b0, READ_NONE);
                end
                need_start = 1'b0;
            end else if (kind < 9) begin
                // truncated frame; drop it with a start flag on the next frame
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) begin
                    r = $urandom;
                    send_byte(r[7:0], k == 0, 1'b0, READ_NONE);
                end
                need_start = 1'b1;
            end else begin
                // noise: random bytes with a sprinkling of start flags
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    r = $urandom;
                    send_byte(r[7:0], $urandom_range(0, 3) == 0, 1'b0, READ_NONE);
                end
                need_start = 1'b1;
            end
        end

        // drain: release valid, let the last results out, then a short tail
        i_in_valid <= 1'b0;
        calm       <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("humidity_sensor_frame_checker_top_tb: done, clean");
        end else begin
            $display("humidity_sensor_frame_checker_top_tb: done, errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("humidity_sensor_frame_checker_top_tb: done, errors");
        $finish;
    end

endmodule
